FILE: src/ossc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_pkg
// Shared types and constants for the one-shot sample capture buffer.
// ----------------------------------------------------------------------------
package ossc_pkg;

    // fixed field widths of the item and result
    localparam int MODE_W     = 2;
    localparam int DIV_W      = 2;
    localparam int PAYLOAD_W  = 48;
    localparam int SEQ_W      = 8;
    localparam int CSTATE_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int RATE_W     = 27;

    // stream and register port widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic [RATE_W-1:0] RATE_RESET = 27'd20000;

    // divider modes
    localparam logic [DIV_W-1:0] DIV_ENABLED = 2'd1;

    // operation carried by each item
    typedef enum logic [MODE_W-1:0] {
        OP_RECORD = 2'd0,
        OP_ARM    = 2'd1,
        OP_STOP   = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    // capture phase
    typedef enum logic [CSTATE_W-1:0] {
        PH_IDLE     = 2'd0,
        PH_ARMED    = 2'd1,
        PH_COMPLETE = 2'd2
    } phase_t;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
    } ossc_cmd_t;

endpackage

FILE: src/ossc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ossc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ossc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_ctrl
// Sequencer: takes one item, waits for the memory read, then loads the
// output register as soon as it is free.
// ----------------------------------------------------------------------------
module ossc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ossc_pkg::ossc_cmd_t cmd
);
    import ossc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    // state register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        s_tready = 1'b0;
        cmd.exec = 1'b0;
        cmd.load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    // a load always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> m_tvalid)
        else $error("load did not raise m_tvalid");

    // an accepted item is always followed by the load state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == ST_LOAD))
        else $error("accepted item not followed by load");

    // a waiting result is not dropped without being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result dropped");

endmodule

FILE: src/ossc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ossc_datapath
// Capture state, pointers, sample memory, rate register and result register.
// ----------------------------------------------------------------------------
module ossc_datapath #(
    parameter int CAPACITY    = 256,
    parameter int SAMPLE_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ossc_pkg::ossc_cmd_t                cmd,
    input  logic [ossc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [ossc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic [ossc_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [ossc_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ossc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ossc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ossc_pkg::APB_DATA_W-1:0]    prdata,
    input  logic                               pready
);
    import ossc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // item fields
    op_t                  op;
    logic [DIV_W-1:0]     div_sel;
    logic [PAYLOAD_W-1:0] payload;
    logic [63:0]          payload_ext;

    // capture state
    phase_t          phase_reg, phase_next;
    logic            div_reg, div_next;
    logic [CW-1:0]   wcount_reg, wcount_next;
    logic [CW-1:0]   rcount_reg, rcount_next;
    logic [CW-1:0]   wcount_inc;
    logic [RATE_W-1:0] rate_reg;

    // pending result from the accepted item
    logic             ok_calc, pop_calc;
    logic             ok_pend_reg, pop_pend_reg;
    logic [SEQ_W-1:0] seq_pend_reg, seq_calc;
    logic [31:0]      rcount_ext;

    // result register
    logic                 ok_out_reg;
    logic [PAYLOAD_W-1:0] payload_out_reg;
    logic [SEQ_W-1:0]     seq_out_reg;
    logic [CSTATE_W-1:0]  cstate_out_reg;
    logic                 div_out_reg;
    logic [COUNT_W-1:0]   scount_out_reg;
    logic [COUNT_W-1:0]   ucount_out_reg;
    logic [31:0]          scount_ext, ucount_ext;
    logic [CW-1:0]        unread;

    // memory signals
    logic                   wr_en, rd_en;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [63:0]            rd_ext;

    logic cfg_wr;

    assign op          = op_t'(s_tuser);
    assign div_sel     = s_tdata[DIV_W-1:0];
    assign payload     = s_tdata[DIV_W +: PAYLOAD_W];
    assign payload_ext = 64'(payload);
    assign wcount_inc  = wcount_reg + 1'b1;
    assign rcount_ext  = 32'(rcount_reg);

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_SAMPLE_RATE))
        begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? APB_DATA_W'(rate_reg) : '0;

    // operation decode
    always_comb
    begin
        phase_next  = phase_reg;
        div_next    = div_reg;
        wcount_next = wcount_reg;
        rcount_next = rcount_reg;
        ok_calc     = 1'b0;
        pop_calc    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (cmd.exec)
        begin
            case (op)
                OP_ARM:
                begin
                    if ((rate_reg != '0) && (phase_reg != PH_ARMED) &&
                        (div_sel <= DIV_ENABLED))
                    begin
                        wcount_next = '0;
                        rcount_next = '0;
                        div_next    = div_sel[0];
                        phase_next  = PH_ARMED;
                        ok_calc     = 1'b1;
                    end
                end
                OP_RECORD:
                begin
                    if (phase_reg == PH_ARMED)
                    begin
                        if (wcount_reg >= CAP_C)
                        begin
                            phase_next = PH_COMPLETE;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wcount_next = wcount_inc;
                            ok_calc     = 1'b1;
                            if (wcount_inc == CAP_C)
                            begin
                                phase_next = PH_COMPLETE;
                            end
                        end
                    end
                end
                OP_STOP:
                begin
                    if (phase_reg == PH_ARMED)
                    begin
                        phase_next = PH_COMPLETE;
                        ok_calc    = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if ((phase_reg != PH_ARMED) && (rcount_reg < wcount_reg))
                    begin
                        rd_en       = 1'b1;
                        rcount_next = rcount_reg + 1'b1;
                        pop_calc    = 1'b1;
                        ok_calc     = 1'b1;
                    end
                end
                default:
                begin
                    ok_calc = 1'b0;
                end
            endcase
        end
    end

    assign seq_calc = pop_calc ? rcount_ext[SEQ_W-1:0] : '0;

    // capture state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            div_reg    <= 1'b0;
            wcount_reg <= '0;
            rcount_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            div_reg    <= div_next;
            wcount_reg <= wcount_next;
            rcount_reg <= rcount_next;
        end
    end

    // pending result, captured with the item
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_pend_reg  <= ok_calc;
            pop_pend_reg <= pop_calc;
            seq_pend_reg <= seq_calc;
        end
    end

    // sample memory
    ossc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wcount_reg[AW-1:0]),
        .wr_data (payload_ext[SAMPLE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rcount_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_ext     = 64'(rd_data);
    assign unread     = wcount_reg - rcount_reg;
    assign scount_ext = 32'(wcount_reg);
    assign ucount_ext = 32'(unread);

    // result register, status taken after the operation
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_out_reg      <= ok_pend_reg;
            payload_out_reg <= pop_pend_reg ? rd_ext[PAYLOAD_W-1:0] : '0;
            seq_out_reg     <= seq_pend_reg;
            cstate_out_reg  <= phase_reg;
            div_out_reg     <= div_reg;
            scount_out_reg  <= scount_ext[COUNT_W-1:0];
            ucount_out_reg  <= ucount_ext[COUNT_W-1:0];
        end
    end

    assign m_tdata = {3'd0, ucount_out_reg, scount_out_reg, div_out_reg,
                      cstate_out_reg, seq_out_reg, payload_out_reg};
    assign m_tuser = ok_out_reg;

    // read pointer never passes the write pointer
    assert property (@(posedge clk) disable iff (!rst_n) rcount_reg <= wcount_reg)
        else $error("read pointer ahead of write pointer");

    // write pointer bounded by the capacity
    assert property (@(posedge clk) disable iff (!rst_n) wcount_reg <= CAP_C)
        else $error("write pointer beyond capacity");

    // memory written only during an armed capture
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> (phase_reg == PH_ARMED))
        else $error("sample written outside armed capture");

    // a successful pop advances the read pointer by one
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (rcount_reg == $past(rcount_reg) + 1'b1))
        else $error("pop did not advance read pointer");

endmodule

FILE: src/one_shot_sample_capture_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_sample_capture_buffer
// One-shot capture of phase voltage samples with in-order read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one item is one operation, chosen by s_tuser
//   (record, arm, stop, pop). Arm clears the pointers and latches the
//   divider mode, record stores a sample while armed, stop ends a capture,
//   pop reads the samples back in order once the capture is not armed.
//   Output stream (m_*): exactly one result per item, with an ok flag in
//   m_tuser and the popped sample plus status in m_tdata.
//   APB port: sample_rate at byte address 0; a rate of zero refuses arm.
// Timing:
//   an item reaches its result in the output register through the accept
//   cycle, which updates the pointers and issues the memory access, and
//   the load state, which takes the registered read of the sample RAM.
//   A new item is accepted only once the last one has loaded its result.
// Reset:
//   idle phase, divider disabled, both counts zero, rate 20000; the sample
//   memory is not cleared, since only written entries are ever read.
// Stall:
//   a result waits in the output register while m_tready is low; one more
//   item is accepted meanwhile and holds its result until the register frees.
// ----------------------------------------------------------------------------
module one_shot_sample_capture_buffer #(
    parameter int CAPACITY    = 256,
    parameter int SAMPLE_BITS = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // divider_select [1:0], sample_payload [49:2], zero fill
    input  logic [ossc_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [ossc_pkg::IN_USER_W-1:0]  s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // popped_payload [47:0], popped_sequence [55:48], capture_state [57:56],
    // divider_state [58], recorded total [67:59], unread total [76:68], zero fill
    output logic [ossc_pkg::OUT_DATA_W-1:0] m_tdata,
    // ok [0]
    output logic [ossc_pkg::OUT_USER_W-1:0] m_tuser,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ossc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ossc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ossc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ossc_pkg::*;

    ossc_cmd_t cmd;

    assign pready = 1'b1;

    // sequencer
    ossc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // capture datapath
    ossc_datapath #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

endmodule
